### rtl/core/falt_pkg.sv
`timescale 1ns / 1ps

package falt_pkg;

  // Window of previous characters; slot 0 is the one just before the current.
  localparam int WIN_DEPTH = 7;

  localparam logic [9:0]  LEVEL_LIMIT = 10'd600;
  localparam logic [15:0] FEET_LIMIT  = 16'd60000;
  localparam logic [6:0]  LEVEL_SCALE = 7'd100;

  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // ALT tag phases
  localparam logic [1:0] PH_SEEK   = 2'd0;
  localparam logic [1:0] PH_BLANKS = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // Pattern codes reported with a result
  localparam logic [1:0] PAT_FL_PREFIX = 2'd0;
  localparam logic [1:0] PAT_F_SUFFIX  = 2'd1;
  localparam logic [1:0] PAT_ALT_TAG   = 2'd2;
  localparam logic [1:0] PAT_FT_SUFFIX = 2'd3;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } falt_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] altitude_ft;
    logic [1:0]  pattern_used;
  } falt_result_t;

  function automatic logic is_num(input logic [7:0] ch);
    return (ch >= CH_0) && (ch <= CH_9);
  endfunction

  function automatic logic [3:0] dval(input logic [7:0] ch);
    logic [7:0] d;
    d = ch - CH_0;
    return d[3:0];
  endfunction

  function automatic logic is_delim(input logic [7:0] ch);
    return (ch == CH_DOT) || (ch == CH_COMMA) || (ch == CH_SPACE) ||
           (ch == CH_CR) || (ch == CH_LF) || (ch == CH_SLASH);
  endfunction

  // Three-digit level value, at most 999.
  function automatic logic [9:0] lvl3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [9:0] s;
    s = 10'(dval(a)) * 10'd100 + 10'(dval(b)) * 10'd10 + 10'(dval(c));
    return s;
  endfunction

  // Three digits forming a level in 1..599.
  function automatic logic lvl3_ok(input logic [7:0] a, input logic [7:0] b,
                                   input logic [7:0] c);
    logic [9:0] s;
    s = lvl3(a, b, c);
    return is_num(a) && is_num(b) && is_num(c) && (s != 10'd0) && (s < LEVEL_LIMIT);
  endfunction

endpackage

### rtl/core/falt_in_stage.sv
`timescale 1ns / 1ps

module falt_in_stage
  import falt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       room,
  output logic       step,
  output falt_item_t item
);

  logic valid;
  logic advance;

  // A final character waits here until the result register has room.
  assign advance  = !valid || !item.last_char || room;
  assign s_tready = advance;
  assign step     = valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s_tvalid) begin
      item.text_char <= s_tdata;
      item.last_char <= s_tlast;
    end
  end

endmodule

### rtl/core/falt_scan.sv
`timescale 1ns / 1ps

module falt_scan
  import falt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  falt_item_t   item,
  output falt_result_t result
);

  logic [7:0]  recent [WIN_DEPTH];
  logic        prefix_hit;
  logic [9:0]  prefix_value;
  logic        suffix_hit;
  logic [9:0]  suffix_value;
  logic [1:0]  tag_phase;
  logic [15:0] tag_value;
  logic [15:0] feet_value;

  logic        prefix_hit_next;
  logic [9:0]  prefix_value_next;
  logic        suffix_hit_next;
  logic [9:0]  suffix_value_next;
  logic [1:0]  tag_phase_next;
  logic [15:0] tag_value_next;
  logic [15:0] feet_value_next;

  always_comb begin
    logic [7:0]  c;
    logic        last;
    logic [19:0] tag_sum;
    logic [16:0] feet_sum;
    logic [16:0] level_ft;
    c        = item.text_char;
    last     = item.last_char;
    level_ft = 17'd0;

    prefix_hit_next   = prefix_hit;
    prefix_value_next = prefix_value;
    suffix_hit_next   = suffix_hit;
    suffix_value_next = suffix_value;
    tag_phase_next    = tag_phase;
    tag_value_next    = tag_value;
    feet_value_next   = feet_value;

    // FL prefix: closed by a non-digit, or by the end of the message
    if (!prefix_hit && !is_num(c) && recent[4] == CH_F && recent[3] == CH_L &&
        lvl3_ok(recent[2], recent[1], recent[0])) begin
      prefix_hit_next   = 1'b1;
      prefix_value_next = lvl3(recent[2], recent[1], recent[0]);
    end else if (!prefix_hit && last && recent[3] == CH_F && recent[2] == CH_L &&
                 lvl3_ok(recent[1], recent[0], c)) begin
      prefix_hit_next   = 1'b1;
      prefix_value_next = lvl3(recent[1], recent[0], c);
    end

    // F suffix: closed by a delimiter, or F as the final character
    if (!suffix_hit && is_delim(c) && recent[0] == CH_F && !is_num(recent[4]) &&
        lvl3_ok(recent[3], recent[2], recent[1])) begin
      suffix_hit_next   = 1'b1;
      suffix_value_next = lvl3(recent[3], recent[2], recent[1]);
    end else if (!suffix_hit && last && c == CH_F && !is_num(recent[3]) &&
                 lvl3_ok(recent[2], recent[1], recent[0])) begin
      suffix_hit_next   = 1'b1;
      suffix_value_next = lvl3(recent[2], recent[1], recent[0]);
    end

    // ALT tag
    tag_sum = 20'(tag_value) * 20'd10 + 20'(dval(c));
    case (tag_phase)
      PH_SEEK: begin
        if (c == CH_T && recent[0] == CH_L && recent[1] == CH_A) begin
          tag_phase_next = PH_BLANKS;
        end
      end
      PH_BLANKS: begin
        if (is_num(c)) begin
          tag_phase_next = PH_DIGITS;
          tag_value_next = 16'(dval(c));
        end else if (c != CH_SPACE && c != CH_TAB) begin
          tag_phase_next = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (is_num(c)) begin
          tag_value_next = (tag_sum > 20'(FEET_LIMIT)) ? FEET_LIMIT : tag_sum[15:0];
        end else begin
          tag_phase_next = PH_DONE;
        end
      end
      default: ;
    endcase

    // FT suffix
    feet_sum = 17'(dval(recent[5])) * 17'd10000 + 17'(dval(recent[4])) * 17'd1000 +
               17'(dval(recent[3])) * 17'd100 + 17'(dval(recent[2])) * 17'd10 +
               17'(dval(recent[1]));
    if (feet_value == 16'd0 && c == CH_T && recent[0] == CH_F && !is_num(recent[6]) &&
        is_num(recent[5]) && is_num(recent[4]) && is_num(recent[3]) &&
        is_num(recent[2]) && is_num(recent[1]) && feet_sum != 17'd0 &&
        feet_sum < 17'(FEET_LIMIT)) begin
      feet_value_next = feet_sum[15:0];
    end

    // Pick by pattern priority
    result.found        = 1'b1;
    result.altitude_ft  = 16'd0;
    result.pattern_used = PAT_FL_PREFIX;
    if (prefix_hit_next) begin
      level_ft            = 17'(prefix_value_next) * 17'(LEVEL_SCALE);
      result.altitude_ft  = level_ft[15:0];
    end else if (suffix_hit_next) begin
      level_ft            = 17'(suffix_value_next) * 17'(LEVEL_SCALE);
      result.altitude_ft  = level_ft[15:0];
      result.pattern_used = PAT_F_SUFFIX;
    end else if ((tag_phase_next == PH_DIGITS || tag_phase_next == PH_DONE) &&
                 tag_value_next != 16'd0 && tag_value_next < FEET_LIMIT) begin
      result.altitude_ft  = tag_value_next;
      result.pattern_used = PAT_ALT_TAG;
    end else if (feet_value_next != 16'd0) begin
      result.altitude_ft  = feet_value_next;
      result.pattern_used = PAT_FT_SUFFIX;
    end else begin
      result.found = 1'b0;
    end
  end

  // Clear everything at the end of each message.
  always_ff @(posedge clk) begin
    if (rst || (step && item.last_char)) begin
      for (int i = 0; i < WIN_DEPTH; i++) recent[i] <= 8'd0;
      prefix_hit   <= 1'b0;
      prefix_value <= 10'd0;
      suffix_hit   <= 1'b0;
      suffix_value <= 10'd0;
      tag_phase    <= PH_SEEK;
      tag_value    <= 16'd0;
      feet_value   <= 16'd0;
    end else if (step) begin
      for (int i = WIN_DEPTH - 1; i > 0; i--) recent[i] <= recent[i - 1];
      recent[0]    <= item.text_char;
      prefix_hit   <= prefix_hit_next;
      prefix_value <= prefix_value_next;
      suffix_hit   <= suffix_hit_next;
      suffix_value <= suffix_value_next;
      tag_phase    <= tag_phase_next;
      tag_value    <= tag_value_next;
      feet_value   <= feet_value_next;
    end
  end

endmodule

### rtl/core/flight_altitude_text_parser_core.sv
`timescale 1ns / 1ps
// Output: a result is registered when its final character leaves the input register.
// Throughput: one character per cycle; the input register feeds the scan logic and the
// result register, so a final character stalls the input only while a result waits untaken.
// Reset: synchronous rst clears the input, scan and result valid state; each message end
// clears the scan state again.

module flight_altitude_text_parser_core
  import falt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_char
  input  logic        s_tlast,   // last_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] found, [16:1] altitude_ft, [23:17] zero
  output logic [1:0]  m_tuser    // [1:0] pattern_used
);

  logic         room;
  logic         step;
  falt_item_t   item;
  falt_result_t scan_result;
  falt_result_t out_result;
  logic         out_valid;

  // The result register can take a new request when empty or being drained.
  assign room = !out_valid || m_tready;

  falt_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .room     (room),
    .step     (step),
    .item     (item)
  );

  falt_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .result (scan_result)
  );

  // Load a result on each final character; drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && item.last_char) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && item.last_char) begin
      out_result <= scan_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_result.altitude_ft, out_result.found};
  assign m_tuser  = out_result.pattern_used;

  // No match reports zero altitude and the first pattern code.
  a_nothing_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_result.found) |->
      (out_result.altitude_ft == 16'd0 && out_result.pattern_used == PAT_FL_PREFIX))
    else $error("empty result carries nonzero fields");

  // A reported altitude lies in the valid feet range.
  a_found_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.found) |->
      (out_result.altitude_ft != 16'd0 && out_result.altitude_ft < FEET_LIMIT))
    else $error("reported altitude out of range");

  // The input only stalls behind a final character held in the input register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (item.last_char && !room))
    else $error("input stalled without a pending final character");

  // A final character that moves on always produces a result next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (step && item.last_char) |=> m_tvalid)
    else $error("final character produced no result");

endmodule
